/* design/fir_filter_assert.svh */
// ---------------------------------------------------------------------------
// FIR filter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FIR_FILTER_ASSERT_SVH
`define FIR_FILTER_ASSERT_SVH

// Condition that must hold at every clock edge.
`define FIR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define FIR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define FIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/fir_pkg.sv */
// ---------------------------------------------------------------------------
// FIR filter package
// Widths, command codes, types and arithmetic constants of the FIR filter.
// ---------------------------------------------------------------------------
package fir_pkg;

  // Filter size and number format.
  localparam int MAX_TAPS    = 64;
  localparam int SAMPLE_BITS = 16;

  // Field widths of the input and configuration beats.
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 6;
  localparam int TAP_CNT_W = 7;

  // Accumulator wide enough to hold the exact sum of all products.
  localparam int ACC_W = 2 * SAMPLE_BITS + $clog2(MAX_TAPS);
  localparam int PROD_W = 2 * SAMPLE_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [TAP_CNT_W-1:0]          tap_cnt_t;

  // Command codes of the input beat.
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // Tap count after reset.
  localparam tap_cnt_t TAP_CNT_RESET = tap_cnt_t'(MAX_TAPS);

  // Rounding offset and saturation limits in accumulator format.
  localparam acc_t ROUND_HALF = acc_t'(1) <<< (SAMPLE_BITS - 2);
  localparam acc_t SAT_HI     = (acc_t'(1) <<< (SAMPLE_BITS - 1)) - acc_t'(1);
  localparam acc_t SAT_LO     = -(acc_t'(1) <<< (SAMPLE_BITS - 1));

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;
    logic clear;
    logic coef_we;
    logic tap_en;
  } cell_ctl_t;

endpackage

/* design/fir_in_if.sv */
// ---------------------------------------------------------------------------
// FIR filter input channel
// Valid/ready channel carrying one command beat: sample, coefficient or clear.
// ---------------------------------------------------------------------------
interface fir_in_if;
  logic                          valid;
  logic                          ready;
  logic [fir_pkg::CMD_W-1:0]     cmd;
  logic [fir_pkg::IDX_W-1:0]     coef_index;
  logic signed [fir_pkg::SAMPLE_BITS-1:0] value;

  modport source (output valid, cmd, coef_index, value, input ready);
  modport sink (input valid, cmd, coef_index, value, output ready);
endinterface

/* design/fir_out_if.sv */
// ---------------------------------------------------------------------------
// FIR filter output channel
// Valid/ready channel carrying one filtered sample and its saturation flag.
// ---------------------------------------------------------------------------
interface fir_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [fir_pkg::SAMPLE_BITS-1:0] filtered;
  logic                                   saturated;

  modport source (output valid, filtered, saturated, input ready);
  modport sink (input valid, filtered, saturated, output ready);
endinterface

/* design/fir_filter.sv */
// ---------------------------------------------------------------------------
// FIR filter top level
// Direct-form FIR filter built as a chain of tap cells with a walking sum.
// ---------------------------------------------------------------------------
// Each input beat is a coefficient write, a delay line clear or a sample.
// Coefficient writes, clears and unused commands give no result. A sample
// shifts into the delay line and then a partial sum walks the 64 tap cells,
// one cell per cycle; the input stays closed until the sum is handed to the
// output register, where the beat waits while the next beat is accepted. If
// a later sum finishes before that result has been taken, the sum waits and
// the input stays closed until the output beat is taken. The tap count
// (1..64, zero acts as 1, larger values as 64) is written on cfg_we_i; the
// user must write it only while idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`include "fir_filter_assert.svh"

module fir_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fir_pkg::TAP_CNT_W-1:0]     cfg_data_i,
  fir_in_if.sink                            in_i,
  fir_out_if.source                         out_o
);

  fir_pkg::tap_cnt_t tap_cnt_q, taps_eff;
  logic              busy_q, launch_q, pend_q;
  logic              accept, sample_acc, coef_acc, clear_acc;
  logic              move, out_free;

  fir_pkg::sample_t  x_out    [fir_pkg::MAX_TAPS];
  fir_pkg::acc_t     psum_out [fir_pkg::MAX_TAPS];
  logic [fir_pkg::MAX_TAPS-1:0] tok_out;

  // Tap count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_cnt_q <= fir_pkg::TAP_CNT_RESET;
    end else if (cfg_we_i) begin
      tap_cnt_q <= cfg_data_i;
    end
  end

  // Effective tap count, clamped to the range 1 to the chain length.
  always_comb begin
    taps_eff = tap_cnt_q;
    if (tap_cnt_q == '0) begin
      taps_eff = fir_pkg::tap_cnt_t'(1);
    end else if (tap_cnt_q > fir_pkg::tap_cnt_t'(fir_pkg::MAX_TAPS)) begin
      taps_eff = fir_pkg::tap_cnt_t'(fir_pkg::MAX_TAPS);
    end
  end

  // Command decode of an accepted beat.
  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    sample_acc = 1'b0;
    coef_acc   = 1'b0;
    clear_acc  = 1'b0;
    unique case (in_i.cmd)
      fir_pkg::CMD_SAMPLE: sample_acc = accept;
      fir_pkg::CMD_COEF:   coef_acc   = accept;
      fir_pkg::CMD_CLEAR:  clear_acc  = accept;
      default: ;
    endcase
  end

  // Sequencer: launch the sum, wait for it, hand it to the output stage.
  assign move = pend_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      launch_q <= sample_acc;
      if (sample_acc) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (tok_out[fir_pkg::MAX_TAPS-1]) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
    end
  end

  // The chain of tap cells; cell 0 holds the newest sample.
  for (genvar k = 0; k < fir_pkg::MAX_TAPS; k++) begin : g_cell
    fir_pkg::cell_ctl_t ctl;
    fir_pkg::sample_t   x_in;
    fir_pkg::acc_t      psum_in;
    logic               tok_in;

    assign ctl.shift   = sample_acc;
    assign ctl.clear   = clear_acc;
    assign ctl.coef_we = coef_acc && (in_i.coef_index == fir_pkg::IDX_W'(k));
    assign ctl.tap_en  = fir_pkg::tap_cnt_t'(k) < taps_eff;

    if (k == 0) begin : g_head
      assign x_in    = in_i.value;
      assign psum_in = '0;
      assign tok_in  = launch_q;
    end else begin : g_body
      assign x_in    = x_out[k-1];
      assign psum_in = psum_out[k-1];
      assign tok_in  = tok_out[k-1];
    end

    fir_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .coef_i (in_i.value),
      .x_i    (x_in),
      .psum_i (psum_in),
      .tok_i  (tok_in),
      .x_o    (x_out[k]),
      .psum_o (psum_out[k]),
      .tok_o  (tok_out[k])
    );
  end

  // Rounding, saturation and the output register.
  fir_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (move),
    .acc_i  (psum_out[fir_pkg::MAX_TAPS-1]),
    .free_o (out_free),
    .out_o  (out_o)
  );

  // Only one sum is ever in flight.
  `FIR_ASSERT_ALWAYS(a_one_sum, $onehot0({pend_q, tok_out, launch_q}), "more than one sum in flight")
  // A sample starts a sum and closes the input.
  `FIR_ASSERT_NEXT(a_launch, sample_acc, launch_q && busy_q && !in_i.ready, "sample did not launch")
  // A walking or waiting sum keeps the block busy.
  `FIR_ASSERT_IMPL(a_busy, (tok_out != '0) || pend_q, busy_q, "sum in flight while idle")
  // A finished sum never overwrites a result that has not been taken.
  `FIR_ASSERT_IMPL(a_no_overwrite, move, !out_o.valid || out_o.ready, "result overwritten")

endmodule

/* design/fir_cell.sv */
// ---------------------------------------------------------------------------
// FIR filter tap cell
// Holds one delayed sample and one coefficient, and adds its product to the
// partial sum that walks down the chain.
// ---------------------------------------------------------------------------
module fir_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fir_pkg::cell_ctl_t  ctl_i,
  input  fir_pkg::sample_t    coef_i,
  input  fir_pkg::sample_t    x_i,
  input  fir_pkg::acc_t       psum_i,
  input  logic                tok_i,
  output fir_pkg::sample_t    x_o,
  output fir_pkg::acc_t       psum_o,
  output logic                tok_o
);

  fir_pkg::sample_t x_q, c_q;
  fir_pkg::acc_t    psum_q, psum_d;
  fir_pkg::prod_t   prod;
  fir_pkg::acc_t    prod_ext;
  logic             tok_q;

  // Product of this tap, sign-extended and gated by the active tap count.
  assign prod     = x_q * c_q;
  assign prod_ext = ctl_i.tap_en ?
      {{(fir_pkg::ACC_W - fir_pkg::PROD_W){prod[fir_pkg::PROD_W-1]}}, prod} : '0;
  assign psum_d   = psum_i + prod_ext;

  // Delay line slot and coefficient storage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      c_q <= '0;
    end else begin
      if (ctl_i.clear) begin
        x_q <= '0;
      end else if (ctl_i.shift) begin
        x_q <= x_i;
      end
      if (ctl_i.coef_we) begin
        c_q <= coef_i;
      end
    end
  end

  // The partial sum moves on with its token and holds otherwise.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= 1'b0;
      psum_q <= '0;
    end else begin
      tok_q <= tok_i;
      if (tok_i) begin
        psum_q <= psum_d;
      end
    end
  end

  assign x_o    = x_q;
  assign psum_o = psum_q;
  assign tok_o  = tok_q;

endmodule

/* design/fir_out.sv */
// ---------------------------------------------------------------------------
// FIR filter output stage
// Rounds and saturates the finished sum and holds it until the beat is taken.
// ---------------------------------------------------------------------------
module fir_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  fir_pkg::acc_t  acc_i,
  output logic           free_o,
  fir_out_if.source      out_o
);

  fir_pkg::acc_t    rnd, shr;
  fir_pkg::sample_t res_d, res_q;
  logic             sat_d, sat_q;
  logic             valid_q;

  // Round half up, then clip to the sample range.
  always_comb begin
    rnd   = acc_i + fir_pkg::ROUND_HALF;
    shr   = rnd >>> (fir_pkg::SAMPLE_BITS - 1);
    res_d = shr[fir_pkg::SAMPLE_BITS-1:0];
    sat_d = 1'b0;
    if (shr > fir_pkg::SAT_HI) begin
      res_d = fir_pkg::SAT_HI[fir_pkg::SAMPLE_BITS-1:0];
      sat_d = 1'b1;
    end else if (shr < fir_pkg::SAT_LO) begin
      res_d = fir_pkg::SAT_LO[fir_pkg::SAMPLE_BITS-1:0];
      sat_d = 1'b1;
    end
  end

  // Output register with its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign free_o          = !valid_q || out_o.ready;
  assign out_o.valid     = valid_q;
  assign out_o.filtered  = res_q;
  assign out_o.saturated = sat_q;

endmodule

/* tb/sv/fir_filter_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// FIR filter testbench
// Streams command beats (coefficient writes, clears, samples and an unused
// code) into the filter over several tap count settings. A local FIR model
// predicts every output beat, and each output beat is checked in order.
// Both channels idle at random, and one long output hold-off backs up the
// input channel.
// ---------------------------------------------------------------------------
module fir_filter_tb;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES  = 700;

  // The one command code that the package leaves unnamed.
  localparam logic [fir_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam longint SAT_MAX = (longint'(1) <<< (fir_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_MIN = -(longint'(1) <<< (fir_pkg::SAMPLE_BITS - 1));

  typedef struct {
    logic [fir_pkg::CMD_W-1:0] cmd;
    logic [fir_pkg::IDX_W-1:0] idx;
    fir_pkg::sample_t          value;
  } in_beat_t;

  typedef struct {
    fir_pkg::sample_t filtered;
    logic             saturated;
  } out_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  fir_pkg::tap_cnt_t cfg_data_i;

  fir_in_if  in_if ();
  fir_out_if out_if ();

  fir_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Model state of the filter.
  fir_pkg::sample_t          coef_tab [fir_pkg::MAX_TAPS] = '{default: '0};
  fir_pkg::sample_t          delay_tab [fir_pkg::MAX_TAPS] = '{default: '0};
  logic [fir_pkg::IDX_W-1:0] newest = '0;
  fir_pkg::tap_cnt_t         tap_setting;

  // Beats waiting to be driven and outputs waiting to be seen.
  in_beat_t  cmd_q [$];
  out_beat_t filt_q [$];

  in_beat_t    cur_beat;
  int unsigned gap_max;
  int unsigned gap_left;
  int unsigned stall_max;
  int unsigned stall_left;
  int unsigned err_count = 0;
  int unsigned cycle_cnt = 0;
  logic        hold_kick = 1'b0;
  logic        hold_started = 1'b0;
  logic        rx_hold = 1'b0;
  int unsigned hold_left = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one accepted beat to the model and queues its output, if any.
  function automatic void filter_step(input in_beat_t b);
    int unsigned               ntaps;
    longint                    acc;
    longint                    r;
    logic [fir_pkg::IDX_W-1:0] pos;
    out_beat_t                 o;
    case (b.cmd)
      fir_pkg::CMD_COEF: begin
        coef_tab[b.idx] = b.value;
      end
      fir_pkg::CMD_CLEAR: begin
        foreach (delay_tab[i]) delay_tab[i] = '0;
        newest = '0;
      end
      fir_pkg::CMD_SAMPLE: begin
        // Zero acts as one tap, anything above the table size as the full table.
        ntaps = tap_setting;
        if (ntaps == 0) ntaps = 1;
        if (ntaps > fir_pkg::MAX_TAPS) ntaps = fir_pkg::MAX_TAPS;
        delay_tab[newest] = b.value;
        acc = 0;
        for (int k = 0; k < ntaps; k++) begin
          pos = newest - fir_pkg::IDX_W'(k);
          acc += longint'(coef_tab[k]) * longint'(delay_tab[pos]);
        end
        // Round half up to Q1.15, then clip.
        r = (acc + (longint'(1) <<< (fir_pkg::SAMPLE_BITS - 2))) >>> (fir_pkg::SAMPLE_BITS - 1);
        o.saturated = 1'b0;
        if (r > SAT_MAX) begin
          r = SAT_MAX;
          o.saturated = 1'b1;
        end
        if (r < SAT_MIN) begin
          r = SAT_MIN;
          o.saturated = 1'b1;
        end
        o.filtered = fir_pkg::sample_t'(r);
        filt_q.push_back(o);
        newest = newest + 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("ERROR cycle %0d: %s", cycle_cnt, what);
  endtask

  function automatic void push_beat(input logic [fir_pkg::CMD_W-1:0] c, input int idx,
                                    input int v);
    in_beat_t b;
    b.cmd = c;
    b.idx = fir_pkg::IDX_W'(idx);
    b.value = fir_pkg::sample_t'(v);
    cmd_q.push_back(b);
  endfunction

  // Mix of full-scale, fully random and small values.
  function automatic fir_pkg::sample_t rand_value();
    case ($urandom_range(0, 5))
      0: return fir_pkg::sample_t'(SAT_MAX);
      1: return fir_pkg::sample_t'(SAT_MIN);
      2, 3: return fir_pkg::sample_t'($urandom);
      default: return fir_pkg::sample_t'(int'($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  function automatic void push_random_beat();
    int unsigned pick;
    logic [fir_pkg::CMD_W-1:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 70) c = fir_pkg::CMD_SAMPLE;
    else if (pick < 90) c = fir_pkg::CMD_COEF;
    else if (pick < 96) c = fir_pkg::CMD_CLEAR;
    else c = CMD_UNUSED;
    push_beat(c, $urandom_range(0, fir_pkg::MAX_TAPS - 1), rand_value());
  endfunction

  // Input driver: one beat at a time from cmd_q, with a random gap after each.
  always @(posedge clk_i) begin : drive_proc
    logic nxt_valid;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.cmd <= '0;
      in_if.coef_index <= '0;
      in_if.value <= '0;
      gap_left = 0;
    end else begin
      nxt_valid = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        filter_step(cur_beat);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() != 0) begin
          cur_beat = cmd_q.pop_front();
          in_if.cmd <= cur_beat.cmd;
          in_if.coef_index <= cur_beat.idx;
          in_if.value <= cur_beat.value;
          nxt_valid = 1'b1;
          gap_left = $urandom_range(0, gap_max);
        end
      end
      in_if.valid <= nxt_valid;
    end
  end

  // Output monitor: checks each output beat and stalls at random after each.
  always @(posedge clk_i) begin : collect_proc
    out_beat_t want;
    logic      nxt_ready;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (filt_q.size() == 0) begin
          report_mismatch($sformatf("output beat %0d with no sample pending",
                                    out_if.filtered));
        end else begin
          want = filt_q.pop_front();
          if (out_if.filtered !== want.filtered)
            report_mismatch($sformatf("filtered %0d, expected %0d",
                                      out_if.filtered, want.filtered));
          if (out_if.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, expected %b",
                                      out_if.saturated, want.saturated));
        end
        stall_left = $urandom_range(0, stall_max);
      end
      if (rx_hold) begin
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_if.ready <= nxt_ready;
    end
  end

  // Long output hold-off, counted here once the stimulus asks for it.
  always @(posedge clk_i) begin : hold_proc
    if (hold_kick && !hold_started) begin
      hold_left = HOLD_CYCLES;
      hold_started = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    rx_hold <= (hold_left > 0);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin : watchdog_proc
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Waits until every beat is sent and every output seen, then lets the block settle.
  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_if.valid || filt_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // One random phase at a given tap count and idling mix.
  task automatic run_phase(input fir_pkg::tap_cnt_t taps, input int n,
                           input int unsigned gmax, input int unsigned smax,
                           input bit with_hold);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= taps;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tap_setting = taps;
    @(negedge clk_i);
    gap_max = gmax;
    stall_max = smax;
    repeat (n) push_random_beat();
    if (with_hold) hold_kick = 1'b1;
  endtask

  // Stimulus.
  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_data_i <= '0;
    tap_setting = fir_pkg::TAP_CNT_RESET;
    gap_max = 3;
    stall_max = 3;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats at the reset tap count.
    push_beat(fir_pkg::CMD_SAMPLE, 0, int'(SAT_MAX));    // all coefficients still zero
    push_beat(fir_pkg::CMD_COEF, 0, 1);
    push_beat(fir_pkg::CMD_SAMPLE, 0, 16384);            // exact half rounds up
    push_beat(fir_pkg::CMD_SAMPLE, 0, -16384);           // negative half rounds up to zero
    push_beat(fir_pkg::CMD_SAMPLE, 0, 16383);
    push_beat(fir_pkg::CMD_SAMPLE, 0, -16385);
    push_beat(fir_pkg::CMD_COEF, fir_pkg::MAX_TAPS - 1, int'(SAT_MIN));
    push_beat(fir_pkg::CMD_COEF, 0, int'(SAT_MIN));
    push_beat(fir_pkg::CMD_SAMPLE, 0, int'(SAT_MIN));    // clips high
    push_beat(fir_pkg::CMD_COEF, 1, int'(SAT_MAX));
    push_beat(fir_pkg::CMD_COEF, 0, int'(SAT_MAX));
    push_beat(fir_pkg::CMD_SAMPLE, 0, int'(SAT_MIN));    // clips low
    push_beat(CMD_UNUSED, 5, 12345);                     // ignored
    push_beat(fir_pkg::CMD_CLEAR, 0, 0);
    push_beat(fir_pkg::CMD_SAMPLE, 0, int'(SAT_MAX));    // only the new sample remains
    push_beat(fir_pkg::CMD_SAMPLE, 0, 0);
    push_beat(fir_pkg::CMD_COEF, 42, -21846);
    push_beat(fir_pkg::CMD_SAMPLE, 63, -1);

    // Random phases over the tap count range, extremes included.
    run_phase(fir_pkg::tap_cnt_t'(1), 80, 12, 12, 1'b0);
    run_phase(fir_pkg::tap_cnt_t'(0), 60, 0, 0, 1'b0);
    run_phase(fir_pkg::tap_cnt_t'(127), 80, 12, 0, 1'b0);
    run_phase(fir_pkg::tap_cnt_t'(fir_pkg::MAX_TAPS), 100, 0, 12, 1'b1);
    run_phase(fir_pkg::tap_cnt_t'($urandom_range(2, fir_pkg::MAX_TAPS - 1)), 100, 12, 12, 1'b0);
    run_phase(fir_pkg::tap_cnt_t'($urandom_range(fir_pkg::MAX_TAPS + 1, 126)), 60, 5, 5, 1'b0);
    run_phase(fir_pkg::tap_cnt_t'($urandom_range(2, fir_pkg::MAX_TAPS - 1)), 100, 0, 0, 1'b0);
    run_phase(fir_pkg::tap_cnt_t'(fir_pkg::MAX_TAPS), 120, 12, 12, 1'b0);
    wait_idle();

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
